// ===== design/dsrt_pkg.sv =====
// shared constants, types and helper functions for the debounced switch relay block
package dsrt_pkg;

	localparam int RELAY_COUNT = 3;
	localparam int FIELD_W     = 3;
	localparam int COUNT_W     = 10;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 10;

	localparam logic [COUNT_W-1:0] COUNT_MAX       = {COUNT_W{1'b1}};
	localparam logic [COUNT_W-1:0] DEBOUNCE_RESET  = COUNT_W'(50);

	localparam logic [1:0] FUNC_TICK    = 2'd0;
	localparam logic [1:0] FUNC_SET     = 2'd1;
	localparam logic [1:0] FUNC_CONSUME = 2'd2;

	localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_MS = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_LOW  = CFG_INDEX_W'(1);

	typedef logic [RELAY_COUNT-1:0] chan_t;
	typedef logic [FIELD_W-1:0]     field_t;
	typedef logic [COUNT_W-1:0]     count_t;

	typedef struct packed {
		logic  fire;
		chan_t sample;
	} tick_t;

	function automatic chan_t to_chan(input field_t f);
		chan_t c;
		c = '0;
		for (int i = 0; i < RELAY_COUNT; i++) begin
			if (i < FIELD_W) begin
				c[i] = f[i];
			end
		end
		return c;
	endfunction

	function automatic field_t to_field(input chan_t c);
		field_t f;
		f = '0;
		for (int i = 0; i < FIELD_W; i++) begin
			if (i < RELAY_COUNT) begin
				f[i] = c[i];
			end
		end
		return f;
	endfunction

	localparam field_t OUT_MASK = to_field({RELAY_COUNT{1'b1}});

endpackage

// ===== design/dsrt_ifs.sv =====
// valid/ready channel interfaces for commands, results and configuration writes
interface dsrt_req_if;
	import dsrt_pkg::*;
	logic   valid;
	logic   ready;
	logic   [1:0] func;
	field_t switch_levels;
	field_t relay_index;
	logic   relay_on;

	modport source (output valid, func, switch_levels, relay_index, relay_on, input ready);
	modport sink (input valid, func, switch_levels, relay_index, relay_on, output ready);
endinterface

interface dsrt_rsp_if;
	import dsrt_pkg::*;
	logic   valid;
	logic   ready;
	field_t drive_levels;
	field_t relay_states;
	field_t pending_changes;
	logic   consumed_flag;
	logic   index_error;

	modport source (output valid, drive_levels, relay_states, pending_changes, consumed_flag,
		index_error, input ready);
	modport sink (input valid, drive_levels, relay_states, pending_changes, consumed_flag,
		index_error, output ready);
endinterface

interface dsrt_cfg_if;
	import dsrt_pkg::*;
	logic valid;
	logic ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== design/dsrt_debounce.sv =====
// per-channel quiet-time counters with raw and stable switch levels
module dsrt_debounce
	import dsrt_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  count_t debounce_ms,
	input  tick_t  tick,
	output chan_t  toggle
);

	logic   primed_q;
	chan_t  raw_q;
	chan_t  stable_q;
	count_t quiet_count_q [RELAY_COUNT];

	chan_t  raw_d;
	chan_t  stable_d;
	count_t quiet_count_d [RELAY_COUNT];

	always_comb begin
		raw_d    = tick.sample;
		stable_d = stable_q;
		toggle   = '0;
		for (int i = 0; i < RELAY_COUNT; i++) begin
			if (!primed_q) begin
				quiet_count_d[i] = '0;
				stable_d[i]      = tick.sample[i];
			end else begin
				if (tick.sample[i] != raw_q[i]) begin
					quiet_count_d[i] = '0;
				end else if (quiet_count_q[i] < COUNT_MAX) begin
					quiet_count_d[i] = quiet_count_q[i] + count_t'(1);
				end else begin
					quiet_count_d[i] = quiet_count_q[i];
				end
				if (quiet_count_d[i] > debounce_ms && tick.sample[i] != stable_q[i]) begin
					toggle[i]   = 1'b1;
					stable_d[i] = tick.sample[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q <= 1'b0;
			raw_q    <= '0;
			stable_q <= '0;
			for (int i = 0; i < RELAY_COUNT; i++) begin
				quiet_count_q[i] <= '0;
			end
		end else if (tick.fire) begin
			primed_q <= 1'b1;
			raw_q    <= raw_d;
			stable_q <= stable_d;
			for (int i = 0; i < RELAY_COUNT; i++) begin
				quiet_count_q[i] <= quiet_count_d[i];
			end
		end
	end

endmodule

// ===== design/debounced_switch_relay_toggle.sv =====
// top level: debounced wall switches toggling relays, set and consume commands
// a command goes from the input stage register to the result register
// throughput: one command per cycle while results are taken, by the state update
//   between the input stage register and the result register
// reset: relays off, changed flags clear, quiet counts zero, first tick loads levels
// reset: debounce_ms is 50 and active_low is 0 until written
module debounced_switch_relay_toggle
	import dsrt_pkg::*;
(
	input logic   clk,
	input logic   arst_n,
	dsrt_req_if.sink   req,
	dsrt_rsp_if.source rsp,
	dsrt_cfg_if.sink   cfg
);

	count_t debounce_q;
	logic   active_low_q;

	logic       valid_s1;
	logic [1:0] func_s1;
	field_t     levels_s1;
	field_t     index_s1;
	logic       on_s1;

	chan_t relay_q;
	chan_t change_q;

	logic   rsp_valid_q;
	field_t drive_q;
	field_t states_q;
	field_t pending_q;
	logic   consumed_q;
	logic   error_q;

	logic  advance;
	tick_t tick;
	chan_t toggle;
	chan_t sel;
	logic  in_range;
	chan_t relay_d;
	chan_t change_d;
	chan_t drive_d;
	logic  consumed_d;
	logic  error_d;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= DEBOUNCE_RESET;
			active_low_q <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_DEBOUNCE_MS: debounce_q   <= cfg.data[COUNT_W-1:0];
				CFG_ACTIVE_LOW:  active_low_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			func_s1   <= req.func;
			levels_s1 <= req.switch_levels;
			index_s1  <= req.relay_index;
			on_s1     <= req.relay_on;
		end
	end

	assign tick.fire   = advance && func_s1 == FUNC_TICK;
	assign tick.sample = to_chan(levels_s1);

	dsrt_debounce u_debounce (
		.clk         (clk),
		.arst_n      (arst_n),
		.debounce_ms (debounce_q),
		.tick        (tick),
		.toggle      (toggle)
	);

	always_comb begin
		for (int i = 0; i < RELAY_COUNT; i++) begin
			sel[i] = index_s1 == FIELD_W'(i);
		end
	end

	assign in_range = |sel;

	always_comb begin
		relay_d    = relay_q;
		change_d   = change_q;
		consumed_d = 1'b0;
		error_d    = 1'b0;
		case (func_s1)
			FUNC_TICK: begin
				relay_d  = relay_q ^ toggle;
				change_d = change_q | toggle;
			end
			FUNC_SET: begin
				if (!in_range) begin
					error_d = 1'b1;
				end else if (|(relay_q & sel) != on_s1) begin
					relay_d  = relay_q ^ sel;
					change_d = change_q | sel;
				end
			end
			FUNC_CONSUME: begin
				if (!in_range) begin
					error_d = 1'b1;
				end else begin
					consumed_d = |(change_q & sel);
					change_d   = change_q & ~sel;
				end
			end
			default: ;
		endcase
		drive_d = active_low_q ? ~relay_d : relay_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relay_q     <= '0;
			change_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				relay_q  <= relay_d;
				change_q <= change_d;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			drive_q    <= to_field(drive_d);
			states_q   <= to_field(relay_d);
			pending_q  <= to_field(change_d);
			consumed_q <= consumed_d;
			error_q    <= error_d;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.drive_levels    = drive_q;
	assign rsp.relay_states    = states_q;
	assign rsp.pending_changes = pending_q;
	assign rsp.consumed_flag   = consumed_q;
	assign rsp.index_error     = error_q;

endmodule

// ===== design/dsrt_checker.sv =====
// port-level assertions for the relay block and the bind that attaches them
module dsrt_checker
	import dsrt_pkg::*;
(
	input logic   clk,
	input logic   arst_n,
	input logic   rsp_valid,
	input logic   rsp_ready,
	input field_t drive_levels,
	input field_t relay_states,
	input field_t pending_changes,
	input logic   consumed_flag,
	input logic   index_error
);

	// stalled result holds its valid
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	// pin levels are the relay states in one polarity or the other
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (drive_levels == relay_states) ||
			(drive_levels == (~relay_states & OUT_MASK)))
		else $error("drive levels disagree with relay states");

	// a consume that reads a flag is in range
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(consumed_flag && index_error))
		else $error("consumed flag with index error");

	// no channel beyond the relay count shows up
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((relay_states | pending_changes | drive_levels) & ~OUT_MASK) == '0)
		else $error("unused channel bits set");

endmodule

bind debounced_switch_relay_toggle dsrt_checker u_dsrt_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.drive_levels    (rsp.drive_levels),
	.relay_states    (rsp.relay_states),
	.pending_changes (rsp.pending_changes),
	.consumed_flag   (rsp.consumed_flag),
	.index_error     (rsp.index_error)
);

// ===== verif/tb.sv =====
// testbench for the debounced switch relay block: bouncing switch ticks and relay commands
`timescale 1ns / 1ps

module tb;
	import dsrt_pkg::*;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int unsigned INDEX_TOP = (1 << FIELD_W) - 1;

	typedef struct packed {
		logic [1:0] func;
		field_t     levels;
		field_t     index;
		logic       turn_on;
	} relay_cmd_t;

	typedef struct packed {
		field_t drive;
		field_t states;
		field_t pending;
		logic   consumed;
		logic   bad_index;
	} relay_status_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	dsrt_req_if req ();
	dsrt_rsp_if rsp ();
	dsrt_cfg_if cfg ();

	debounced_switch_relay_toggle uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg(cfg)
	);

	relay_cmd_t    queued_cmds[$];
	relay_status_t awaited_status[$];

	logic        req_took = 1'b0;
	logic        idle_on = 1'b1;
	int unsigned send_gap = 0;
	int unsigned recv_gap = 0;
	int unsigned mismatch_count = 0;

	// relay controller state as the block should hold it
	count_t debounce_q = DEBOUNCE_RESET;
	logic   active_low_q = 1'b0;
	chan_t  relay_q = '0;
	chan_t  change_q = '0;
	chan_t  raw_q = '0;
	chan_t  stable_q = '0;
	count_t quiet_q [RELAY_COUNT] = '{default: '0};
	logic   primed_q = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic relay_status_t predict_relays(input relay_cmd_t c);
		relay_status_t s;
		chan_t levels_now;
		s = '0;
		levels_now = chan_t'(c.levels);
		case (c.func)
			FUNC_TICK: begin
				if (!primed_q) begin
					raw_q = levels_now;
					stable_q = levels_now;
					for (int i = 0; i < RELAY_COUNT; i++) quiet_q[i] = '0;
					primed_q = 1'b1;
				end else begin
					for (int i = 0; i < RELAY_COUNT; i++) begin
						if (levels_now[i] != raw_q[i]) begin
							quiet_q[i] = '0;
							raw_q[i] = levels_now[i];
						end else if (quiet_q[i] != COUNT_MAX) begin
							quiet_q[i] = quiet_q[i] + 1'b1;
						end
						if (quiet_q[i] > debounce_q && levels_now[i] != stable_q[i]) begin
							stable_q[i] = levels_now[i];
							relay_q[i] = ~relay_q[i];
							change_q[i] = 1'b1;
						end
					end
				end
			end
			FUNC_SET, FUNC_CONSUME: begin
				if (c.index >= RELAY_COUNT) begin
					s.bad_index = 1'b1;
				end else if (c.func == FUNC_SET) begin
					if (relay_q[c.index] != c.turn_on) begin
						relay_q[c.index] = c.turn_on;
						change_q[c.index] = 1'b1;
					end
				end else begin
					s.consumed = change_q[c.index];
					change_q[c.index] = 1'b0;
				end
			end
			default: begin
			end
		endcase
		s.drive = field_t'(active_low_q ? ~relay_q : relay_q);
		s.states = field_t'(relay_q);
		s.pending = field_t'(change_q);
		return s;
	endfunction

	task automatic flag_status(input string why, input relay_status_t want,
		input relay_status_t got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%0t %s: expected drive=%b states=%b pending=%b consumed=%b err=%b",
				$realtime, why, want.drive, want.states, want.pending, want.consumed,
				want.bad_index);
			$display("%0t %s: actual   drive=%b states=%b pending=%b consumed=%b err=%b",
				$realtime, why, got.drive, got.states, got.pending, got.consumed,
				got.bad_index);
		end
	endtask

	// command driver
	always @(negedge clk) begin
		relay_cmd_t c;
		if (arst_n && (!req.valid || req_took)) begin
			if (send_gap != 0) begin
				send_gap <= send_gap - 1;
				req.valid <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				send_gap <= $urandom_range(0, 2);
				req.valid <= 1'b0;
			end else if (queued_cmds.size() != 0) begin
				c = queued_cmds.pop_front();
				req.valid <= 1'b1;
				req.func <= c.func;
				req.switch_levels <= c.levels;
				req.relay_index <= c.index;
				req.relay_on <= c.turn_on;
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// result backpressure
	always @(negedge clk) begin
		if (recv_gap != 0) begin
			recv_gap <= recv_gap - 1;
			rsp.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			recv_gap <= $urandom_range(0, 2);
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	// monitor and checker
	always @(posedge clk) begin
		relay_cmd_t    seen_cmd;
		relay_status_t got;
		relay_status_t want;
		req_took <= arst_n && req.valid && req.ready;
		if (arst_n) begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_DEBOUNCE_MS: debounce_q = count_t'(cfg.data);
					CFG_ACTIVE_LOW:  active_low_q = cfg.data[0];
					default: begin
					end
				endcase
			end
			if (req.valid && req.ready) begin
				seen_cmd.func = req.func;
				seen_cmd.levels = req.switch_levels;
				seen_cmd.index = req.relay_index;
				seen_cmd.turn_on = req.relay_on;
				awaited_status.push_back(predict_relays(seen_cmd));
			end
			if (rsp.valid && rsp.ready) begin
				got.drive = rsp.drive_levels;
				got.states = rsp.relay_states;
				got.pending = rsp.pending_changes;
				got.consumed = rsp.consumed_flag;
				got.bad_index = rsp.index_error;
				if (awaited_status.size() == 0) begin
					flag_status("unexpected result", 'x, got);
				end else begin
					want = awaited_status.pop_front();
					if (got !== want) flag_status("result mismatch", want, got);
				end
			end
		end
	end

	task automatic push_tick(input field_t lv);
		relay_cmd_t c;
		c.func = FUNC_TICK;
		c.levels = lv;
		c.index = field_t'($urandom);
		c.turn_on = 1'($urandom);
		queued_cmds.push_back(c);
	endtask

	task automatic push_cmd(input logic [1:0] f, input field_t idx, input logic turn_on);
		relay_cmd_t c;
		c.func = f;
		c.levels = field_t'($urandom);
		c.index = idx;
		c.turn_on = turn_on;
		queued_cmds.push_back(c);
	endtask

	task automatic settle();
		do @(posedge clk);
		while (queued_cmds.size() != 0 || req.valid || awaited_status.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		do @(posedge clk);
		while (!(cfg.valid && cfg.ready));
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic configure(input int unsigned debounce, input logic low_on);
		logic [CFG_DATA_W-1:0] polarity_word;
		polarity_word = CFG_DATA_W'($urandom);
		polarity_word[0] = low_on;
		settle();
		write_reg(CFG_DEBOUNCE_MS, CFG_DATA_W'(debounce));
		write_reg(CFG_ACTIVE_LOW, polarity_word);
	endtask

	// switch presses: a little bounce, then a hold of random length with commands mixed in
	task automatic press_sequences(input int unsigned n, input int unsigned hold_max);
		field_t      target;
		int unsigned sent;
		relay_cmd_t  junk;
		sent = 0;
		target = field_t'($urandom);
		while (sent < n) begin
			if ($urandom_range(0, 9) == 0) begin
				junk = relay_cmd_t'($urandom);
				queued_cmds.push_back(junk);
				sent++;
			end else begin
				repeat ($urandom_range(0, 3)) begin
					push_tick(field_t'($urandom));
					sent++;
				end
				target ^= field_t'($urandom_range(1, INDEX_TOP));
				repeat ($urandom_range(0, hold_max)) begin
					if ($urandom_range(0, 4) == 0) begin
						push_cmd($urandom_range(0, 1) ? FUNC_SET : FUNC_CONSUME,
							($urandom_range(0, 5) == 0) ?
								field_t'($urandom_range(RELAY_COUNT, INDEX_TOP)) :
								field_t'($urandom_range(0, RELAY_COUNT - 1)),
							1'($urandom));
					end else begin
						push_tick(target);
					end
					sent++;
				end
			end
		end
	endtask

	initial begin
		int unsigned mid_debounce;
		req.valid = 1'b0;
		req.func = FUNC_TICK;
		req.switch_levels = '0;
		req.relay_index = '0;
		req.relay_on = 1'b0;
		rsp.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = CFG_DEBOUNCE_MS;
		cfg.data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// commands before the first tick, bad indexes, unused function code
		push_cmd(FUNC_UNUSED, field_t'($urandom), 1'b1);
		push_cmd(FUNC_SET, field_t'(0), 1'b1);
		push_cmd(FUNC_SET, field_t'(0), 1'b1);
		push_cmd(FUNC_CONSUME, field_t'(0), 1'b0);
		push_cmd(FUNC_CONSUME, field_t'(0), 1'b0);
		push_cmd(FUNC_SET, field_t'(INDEX_TOP), 1'b1);
		push_cmd(FUNC_CONSUME, field_t'(RELAY_COUNT), 1'b0);
		push_cmd(FUNC_SET, field_t'(2), 1'b1);
		push_cmd(FUNC_SET, field_t'(2), 1'b0);
		push_cmd(FUNC_CONSUME, field_t'(2), 1'b0);
		// first tick loads levels, next one restarts every quiet count
		push_tick(3'b101);
		push_tick(3'b010);
		repeat (3) push_tick(3'b010);
		push_cmd(FUNC_UNUSED, field_t'($urandom), 1'b0);

		// saturated quiet counts never pass 1023
		configure(COUNT_MAX, 1'b0);
		for (int k = 0; k < 1030; k++) begin
			if (k % 200 == 199) push_cmd(FUNC_CONSUME, field_t'(k % RELAY_COUNT), 1'b0);
			else push_tick(3'b010);
		end
		configure(1000, 1'b1);
		push_tick(3'b010);
		for (int k = 0; k < RELAY_COUNT; k++) push_cmd(FUNC_CONSUME, field_t'(k), 1'b0);
		push_cmd(FUNC_SET, field_t'(1), 1'b0);
		configure(0, 1'b1);
		push_tick(3'b101);
		push_tick(3'b101);
		push_tick(3'b000);
		push_tick(3'b111);
		push_tick(3'b111);

		configure(0, 1'b1);
		press_sequences(70, 4);
		configure(1, 1'b0);
		press_sequences(60, 5);
		mid_debounce = $urandom_range(2, 9);
		configure(mid_debounce, 1'($urandom));
		press_sequences(60, mid_debounce + 4);
		configure(20, 1'b1);
		press_sequences(60, 25);
		configure(0, 1'b0);
		idle_on <= 1'b0;
		press_sequences(50, 4);

		settle();
		if (mismatch_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#3_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
